/* design/voxel_face_vertex_emitter_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the voxel face vertex emitter
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef VOXEL_FACE_VERTEX_EMITTER_ASSERT_SVH
`define VOXEL_FACE_VERTEX_EMITTER_ASSERT_SVH

// Same-cycle implication.
`define VFVE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vfve assertion failed");

// Next-cycle implication.
`define VFVE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vfve assertion failed");

`endif

/* design/vfve_pkg.sv */
// ---------------------------------------------------------------------------
// vfve_pkg
// Shared types, face tables and helpers for the voxel face vertex emitter.
// ---------------------------------------------------------------------------
`default_nettype none

package vfve_pkg;

    localparam int COORD_W     = 8;
    localparam int COLOR_W     = 8;
    localparam int MASK_W      = 6;
    localparam int QUEUE_DEPTH = 2;

    // Face mask bits, visiting order -x, +x, -y, +y, -z, +z
    localparam logic [MASK_W-1:0] FACE_NEG_X = 6'b100000;
    localparam logic [MASK_W-1:0] FACE_POS_X = 6'b010000;
    localparam logic [MASK_W-1:0] FACE_NEG_Y = 6'b001000;
    localparam logic [MASK_W-1:0] FACE_POS_Y = 6'b000100;
    localparam logic [MASK_W-1:0] FACE_NEG_Z = 6'b000010;
    localparam logic [MASK_W-1:0] FACE_POS_Z = 6'b000001;

    localparam logic [2:0] QUAD_LAST_STEP = 3'd3;
    localparam logic [2:0] TRI_LAST_STEP  = 3'd5;

    // Corner signs {x,y,z}, 1 = plus one, 0 = minus one
    localparam logic [2:0] FACE_CORNER [0:5][0:3] = '{
        '{3'b001, 3'b000, 3'b011, 3'b010},
        '{3'b100, 3'b101, 3'b110, 3'b111},
        '{3'b001, 3'b101, 3'b000, 3'b100},
        '{3'b010, 3'b110, 3'b011, 3'b111},
        '{3'b000, 3'b100, 3'b010, 3'b110},
        '{3'b101, 3'b001, 3'b111, 3'b011}
    };

    // Corner orders: quad 1,3,4,2 ; triangles 1,3,2,2,3,4
    localparam logic [1:0] QUAD_SEQ [0:3] = '{2'd0, 2'd2, 2'd3, 2'd1};
    localparam logic [1:0] TRI_SEQ  [0:5] = '{2'd0, 2'd2, 2'd1, 2'd1, 2'd2, 2'd3};

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [MASK_W-1:0]  mask;
        logic               mode;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last;
    } vertex_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // First visible face in visiting order
    function automatic logic [2:0] face_index(input logic [MASK_W-1:0] mask);
        logic [2:0] idx;
        idx = 3'd5;
        if ((mask & FACE_NEG_X) != '0)      idx = 3'd0;
        else if ((mask & FACE_POS_X) != '0) idx = 3'd1;
        else if ((mask & FACE_NEG_Y) != '0) idx = 3'd2;
        else if ((mask & FACE_POS_Y) != '0) idx = 3'd3;
        else if ((mask & FACE_NEG_Z) != '0) idx = 3'd4;
        return idx;
    endfunction

    function automatic logic [MASK_W-1:0] face_bit(input logic [2:0] idx);
        return FACE_NEG_X >> idx;
    endfunction

    function automatic logic [COORD_W-1:0] shift_coord(input logic [COORD_W-1:0] c,
                                                       input logic plus);
        return plus ? c + COORD_W'(1) : c - COORD_W'(1);
    endfunction

endpackage

`default_nettype wire

/* design/voxel_face_vertex_emitter.sv */
// Path of a voxel: front register, queue slot, sequencer voxel register, vertex register.
// Throughput: one vertex per cycle while results are popped; n visible faces give 4n
// vertices in quad mode, 6n in triangle mode (at most 36), none for an empty mask.
// Back-to-back voxels follow with no gap; the face/corner sequencer sets the rate.
// Reset (rst_n low, async): queue and output empty, primitive_mode = 1 (triangles).
// ---------------------------------------------------------------------------
// voxel_face_vertex_emitter
// Cube face meshing: one voxel in, its visible face corner vertices out.
// ---------------------------------------------------------------------------
`default_nettype none

`include "voxel_face_vertex_emitter_assert.svh"

module voxel_face_vertex_emitter #(
    parameter int QUEUE_DEPTH = vfve_pkg::QUEUE_DEPTH
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        push,
    output logic       full,
    input  wire [7:0]  voxel_x,
    input  wire [7:0]  voxel_y,
    input  wire [7:0]  voxel_z,
    input  wire [7:0]  color_red,
    input  wire [7:0]  color_green,
    input  wire [7:0]  color_blue,
    input  wire [5:0]  face_mask,
    output logic       empty,
    input  wire        pop,
    output logic [7:0] vertex_x,
    output logic [7:0] vertex_y,
    output logic [7:0] vertex_z,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic       last_vertex,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire        cfg_data
);

    logic                    mode_reg, mode_next;
    vfve_pkg::item_t         in_item;
    vfve_pkg::item_t         fq_item;
    vfve_pkg::item_t         qb_item;
    vfve_pkg::queue_status_t q_stat;
    logic                    q_push;
    logic                    q_pop;
    logic                    out_valid;
    vfve_pkg::vertex_t       out_vertex;

    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    assign in_item.x     = voxel_x;
    assign in_item.y     = voxel_y;
    assign in_item.z     = voxel_z;
    assign in_item.red   = color_red;
    assign in_item.green = color_green;
    assign in_item.blue  = color_blue;
    assign in_item.mask  = face_mask;
    assign in_item.mode  = mode_reg;

    vfve_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .mode    (mode_reg),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_item  (fq_item)
    );

    vfve_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (fq_item),
        .rd_en   (q_pop),
        .rd_item (qb_item),
        .stat    (q_stat)
    );

    vfve_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .q_item     (qb_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_vertex (out_vertex),
        .pop        (pop)
    );

    assign empty       = !out_valid;
    assign vertex_x    = out_vertex.x;
    assign vertex_y    = out_vertex.y;
    assign vertex_z    = out_vertex.z;
    assign out_red     = out_vertex.red;
    assign out_green   = out_vertex.green;
    assign out_blue    = out_vertex.blue;
    assign last_vertex = out_vertex.last;

    // queue is never written while full nor read while empty
    `VFVE_ASSERT_IMP(a_no_overflow, q_push, !q_stat.full)
    `VFVE_ASSERT_IMP(a_no_underflow, q_pop, !q_stat.empty)
    // front stalls only on queue back-pressure
    `VFVE_ASSERT_IMP(a_full_from_queue, full, q_stat.full)
    // an unpopped result stays on the ports
    `VFVE_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(out_vertex))

endmodule

`default_nettype wire

/* design/vfve_front.sv */
// ---------------------------------------------------------------------------
// vfve_front
// Takes voxels, drops empty masks, tags the primitive mode, feeds the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module vfve_front (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    output logic                  full,
    input  wire vfve_pkg::item_t  in_item,
    input  wire                   mode,
    input  wire vfve_pkg::queue_status_t q_stat,
    output logic                  q_push,
    output vfve_pkg::item_t       q_item
);

    logic            valid_reg;
    logic            valid_next;
    vfve_pkg::item_t item_reg;
    vfve_pkg::item_t item_next;
    logic            accept;
    logic            keep;

    assign full   = valid_reg && q_stat.full;
    assign accept = push && !full;
    assign keep   = accept && (in_item.mask != '0);
    assign q_push = valid_reg && !q_stat.full;
    assign q_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (keep)
        begin
            valid_next     = 1'b1;
            item_next      = in_item;
            item_next.mode = mode;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

/* design/vfve_queue.sv */
// ---------------------------------------------------------------------------
// vfve_queue
// Short FIFO of voxel requests between the front and the vertex sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module vfve_queue #(
    parameter int QUEUE_DEPTH = vfve_pkg::QUEUE_DEPTH
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   wr_en,
    input  wire vfve_pkg::item_t  wr_item,
    input  wire                   rd_en,
    output vfve_pkg::item_t       rd_item,
    output vfve_pkg::queue_status_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    vfve_pkg::item_t  slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_item    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

/* design/vfve_back.sv */
// ---------------------------------------------------------------------------
// vfve_back
// Walks a voxel's visible faces and corners, one vertex per cycle unless held by pop.
// ---------------------------------------------------------------------------
`default_nettype none

module vfve_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire vfve_pkg::queue_status_t q_stat,
    input  wire vfve_pkg::item_t  q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    output vfve_pkg::vertex_t     out_vertex,
    input  wire                   pop
);

    logic                         busy_reg, busy_next;
    vfve_pkg::item_t              cur_reg, cur_next;
    logic [vfve_pkg::MASK_W-1:0]  mask_reg, mask_next;
    logic [2:0]                   step_reg, step_next;
    logic                         ovalid_reg, ovalid_next;
    vfve_pkg::vertex_t            vert_reg, vert_next;

    logic                         advance;
    logic                         emit;
    logic                         load;
    logic [2:0]                   face;
    logic [2:0]                   step_last;
    logic                         at_last_step;
    logic [vfve_pkg::MASK_W-1:0]  mask_left;
    logic                         item_done;
    logic [1:0]                   corner;
    logic [2:0]                   signs;

    assign advance      = !ovalid_reg || pop;
    assign emit         = busy_reg && advance;
    assign face         = vfve_pkg::face_index(mask_reg);
    assign step_last    = cur_reg.mode ? vfve_pkg::TRI_LAST_STEP : vfve_pkg::QUAD_LAST_STEP;
    assign at_last_step = (step_reg == step_last);
    assign mask_left    = mask_reg & ~vfve_pkg::face_bit(face);
    assign item_done    = at_last_step && (mask_left == '0);
    // next voxel is picked up in the same cycle the last vertex leaves
    assign load         = !q_stat.empty && (!busy_reg || (emit && item_done));
    assign q_pop        = load;
    assign corner       = cur_reg.mode ? vfve_pkg::TRI_SEQ[step_reg]
                                       : vfve_pkg::QUAD_SEQ[step_reg[1:0]];
    assign signs        = vfve_pkg::FACE_CORNER[face][corner];

    assign out_valid  = ovalid_reg;
    assign out_vertex = vert_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        cur_next    = cur_reg;
        mask_next   = mask_reg;
        step_next   = step_reg;
        ovalid_next = ovalid_reg;
        vert_next   = vert_reg;

        if (emit)
        begin
            ovalid_next     = 1'b1;
            vert_next.x     = vfve_pkg::shift_coord(cur_reg.x, signs[2]);
            vert_next.y     = vfve_pkg::shift_coord(cur_reg.y, signs[1]);
            vert_next.z     = vfve_pkg::shift_coord(cur_reg.z, signs[0]);
            vert_next.red   = cur_reg.red;
            vert_next.green = cur_reg.green;
            vert_next.blue  = cur_reg.blue;
            vert_next.last  = item_done;
            if (at_last_step)
            begin
                step_next = '0;
                mask_next = mask_left;
                if (item_done)
                begin
                    busy_next = 1'b0;
                end
            end
            else
            begin
                step_next = step_reg + 3'd1;
            end
        end
        else if (pop)
        begin
            ovalid_next = 1'b0;
        end

        if (load)
        begin
            busy_next = 1'b1;
            cur_next  = q_item;
            mask_next = q_item.mask;
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            mask_reg   <= '0;
            step_reg   <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
            mask_reg   <= mask_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        vert_reg <= vert_next;
    end

endmodule

`default_nettype wire
